/* hw/rtl/apl_pkg.sv */
package apl_pkg;

  // Field widths of the input and result transactions.
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned EVENT_W = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BIDX_W  = 9;
  localparam int unsigned RIDX_W  = 8;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned VAL_W   = 13;
  localparam int unsigned CODE_W  = 12;
  localparam int unsigned BIT_W   = 3;

  // Bit of the event word that selects add over remove.
  localparam int unsigned ADD_BIT = 15;

  // Default list depth.
  localparam int unsigned DEF_LIST_DEPTH = 256;

  // Configuration port.
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic [CODE_W-1:0] WLOW_RST  = 12'd0;
  localparam logic [CODE_W-1:0] WHIGH_RST = 12'd1152;
  localparam logic REG_WLOW  = 1'b0;
  localparam logic REG_WHIGH = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_EVENT = 2'd1,
    MODE_SCAN  = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_NEXT,
    ST_READ,
    ST_DONE
  } state_e;

  // Event window handed from the register file to the core.
  typedef struct packed {
    logic [CODE_W-1:0] window_low;
    logic [CODE_W-1:0] window_high;
  } cfg_t;

endpackage

/* hw/rtl/apl_in_if.sv */
interface apl_in_if;
  logic                         valid;
  logic                         ready;
  logic [apl_pkg::MODE_W-1:0]   mode;
  logic [apl_pkg::EVENT_W-1:0]  event_word;
  logic [apl_pkg::BYTE_W-1:0]   new_byte;
  logic [apl_pkg::BYTE_W-1:0]   old_byte;
  logic [apl_pkg::BIDX_W-1:0]   byte_index;
  logic [apl_pkg::RIDX_W-1:0]   read_index;

  modport source (
    output valid, mode, event_word, new_byte, old_byte, byte_index, read_index,
    input  ready
  );

  modport sink (
    input  valid, mode, event_word, new_byte, old_byte, byte_index, read_index,
    output ready
  );
endinterface

/* hw/rtl/apl_out_if.sv */
interface apl_out_if;
  logic                       valid;
  logic                       ready;
  logic [apl_pkg::LEN_W-1:0]  list_length;
  logic [apl_pkg::VAL_W-1:0]  entry_value;
  logic                       dropped;

  modport source (
    output valid, list_length, entry_value, dropped,
    input  ready
  );

  modport sink (
    input  valid, list_length, entry_value, dropped,
    output ready
  );
endinterface

/* hw/rtl/apl_cfg.sv */
module apl_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [apl_pkg::CFG_AW-1:0]  paddr,
  input  logic [apl_pkg::CFG_DW-1:0]  pwdata,
  output logic [apl_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output apl_pkg::cfg_t               cfg_o
);
  import apl_pkg::*;

  logic [CODE_W-1:0] wlow_q, wlow_d;
  logic [CODE_W-1:0] whigh_q, whigh_d;
  logic              wr_en;
  logic              reg_sel;

  // Registers sit on word addresses; the low address bits are the byte offset.
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register write decode.
  always_comb begin
    wlow_d  = wlow_q;
    whigh_d = whigh_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_WLOW:  wlow_d  = pwdata[CODE_W-1:0];
        REG_WHIGH: whigh_d = pwdata[CODE_W-1:0];
        default:   wlow_d  = wlow_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlow_q  <= WLOW_RST;
      whigh_q <= WHIGH_RST;
    end else begin
      wlow_q  <= wlow_d;
      whigh_q <= whigh_d;
    end
  end

  // Read mux.
  always_comb begin
    unique case (reg_sel)
      REG_WLOW:  prdata = CFG_DW'(wlow_q);
      REG_WHIGH: prdata = CFG_DW'(whigh_q);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o.window_low  = wlow_q;
  assign cfg_o.window_high = whigh_q;

endmodule

/* hw/rtl/active_point_list_core.sv */
// Clear, and an event outside the window, go straight to the done state; a read fetches one
// entry; an event searches the list and a remove shifts the later entries down; a byte scan
// searches once per rising bit. Throughput: one transaction at a time; input is ready again
// as the result is registered. The list memory, one write and one registered
// read port, sets the pace at one entry per cycle. Reset is asynchronous and active low; it
// empties the list and restores the window registers. List memory contents are not cleared.
module active_point_list_core #(
  parameter int unsigned LIST_DEPTH = apl_pkg::DEF_LIST_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  apl_in_if.sink                      in_i,
  apl_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [apl_pkg::CFG_AW-1:0]  paddr,
  input  logic [apl_pkg::CFG_DW-1:0]  pwdata,
  output logic [apl_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import apl_pkg::*;

  localparam int unsigned IDX_W = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BYTE_W - 1);

  cfg_t cfg;

  // Configuration registers.
  apl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e             state_q, state_d;
  mode_e              mode_q, mode_d;
  logic               add_q, add_d;
  logic [VAL_W-1:0]   target_q, target_d;
  logic [BIDX_W-1:0]  bi_q, bi_d;
  logic [BYTE_W-1:0]  rising_q, rising_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [RIDX_W-1:0]  ri_q, ri_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   scan_q, scan_d;
  logic               pend_q, pend_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic               lost_q, lost_d;
  logic [VAL_W-1:0]   value_q, value_d;

  logic               out_valid_q, out_valid_d;
  logic [LEN_W-1:0]   out_len_q, out_len_d;
  logic [VAL_W-1:0]   out_val_q, out_val_d;
  logic               out_drop_q, out_drop_d;

  logic [VAL_W-1:0]   mem [LIST_DEPTH];
  logic [VAL_W-1:0]   rdata_q;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [VAL_W-1:0]   mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;

  logic               in_fire;
  logic [CODE_W-1:0]  code;
  logic               in_win;
  logic               hit;
  logic               issue;
  logic               last_bit;
  logic               out_load;
  logic               rd_in_range;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign code       = in_i.event_word[CODE_W-1:0];
  assign in_win     = (code >= cfg.window_low) && (code <= cfg.window_high);
  assign hit        = pend_q && (rdata_q == target_q);
  assign issue      = (scan_q < count_q);
  assign last_bit   = (bit_q == LAST_BIT);
  assign out_load   = !out_valid_q || out_o.ready;
  assign rd_in_range = (CMP_W'(ri_q) < CMP_W'(count_q));

  // List memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (mode_e'(in_i.mode))
            MODE_CLEAR: state_d = ST_DONE;
            MODE_EVENT: state_d = in_win ? ST_SEARCH : ST_DONE;
            MODE_SCAN:  state_d = ST_NEXT;
            MODE_READ:  state_d = ST_READ;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_SEARCH: begin
        priority if (hit && !add_q) begin
          state_d = ST_SHIFT;
        end else if (hit || !issue) begin
          state_d = ((mode_q == MODE_SCAN) && !last_bit) ? ST_NEXT : ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (!issue) begin
          state_d = ST_DONE;
        end
      end
      ST_NEXT: begin
        priority if (rising_q[bit_q]) begin
          state_d = ST_SEARCH;
        end else if (last_bit) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        if (pend_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control of the sequencer.
  always_comb begin
    mode_d    = mode_q;
    add_d     = add_q;
    target_d  = target_q;
    bi_d      = bi_q;
    rising_d  = rising_q;
    bit_d     = bit_q;
    ri_d      = ri_q;
    count_d   = count_q;
    scan_d    = scan_q;
    pend_d    = pend_q;
    pos_d     = pos_q;
    lost_d    = lost_q;
    value_d   = value_q;
    mem_we    = 1'b0;
    mem_waddr = count_q[IDX_W-1:0];
    mem_wdata = target_q;
    mem_raddr = (state_q == ST_READ) ? IDX_W'(ri_q) : scan_q[IDX_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          mode_d   = mode_e'(in_i.mode);
          add_d    = (mode_e'(in_i.mode) == MODE_SCAN) || in_i.event_word[ADD_BIT];
          target_d = VAL_W'(code) + VAL_W'(1);
          bi_d     = in_i.byte_index;
          rising_d = in_i.new_byte & ~in_i.old_byte;
          bit_d    = '0;
          ri_d     = in_i.read_index;
          scan_d   = '0;
          pend_d   = 1'b0;
          lost_d   = 1'b0;
          value_d  = '0;
          if (mode_e'(in_i.mode) == MODE_CLEAR) begin
            count_d = '0;
          end
        end
      end
      ST_SEARCH: begin
        // Compare the entry read last cycle while the next one is fetched.
        priority if (hit) begin
          if (!add_q) begin
            scan_d = CNT_W'(pos_q) + CNT_W'(1);
            pend_d = 1'b0;
          end
        end else if (!issue) begin
          if (add_q) begin
            if (count_q == CNT_W'(LIST_DEPTH)) begin
              lost_d = 1'b1;
            end else begin
              mem_we  = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
          end
        end else begin
          pend_d = 1'b1;
          pos_d  = scan_q[IDX_W-1:0];
          scan_d = scan_q + CNT_W'(1);
        end
        if ((hit || !issue) && (mode_q == MODE_SCAN) && !last_bit) begin
          bit_d = bit_q + BIT_W'(1);
        end
      end
      ST_SHIFT: begin
        // Each entry read moves down by one position, written from the registered read data.
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q - IDX_W'(1);
          mem_wdata = rdata_q;
        end
        if (issue) begin
          pend_d = 1'b1;
          pos_d  = scan_q[IDX_W-1:0];
          scan_d = scan_q + CNT_W'(1);
        end else begin
          pend_d  = 1'b0;
          count_d = count_q - CNT_W'(1);
        end
      end
      ST_NEXT: begin
        // Walk the rising bits from bit 0 up; each one starts a search.
        if (rising_q[bit_q]) begin
          target_d = VAL_W'({bi_q, bit_q}) + VAL_W'(1);
          scan_d   = '0;
          pend_d   = 1'b0;
        end else if (!last_bit) begin
          bit_d = bit_q + BIT_W'(1);
        end
      end
      ST_READ: begin
        if (!pend_q) begin
          pend_d = 1'b1;
        end else begin
          value_d = rd_in_range ? rdata_q : '0;
        end
      end
      ST_DONE: begin
        pend_d = 1'b0;
      end
      default: pend_d = 1'b0;
    endcase
  end

  // Result register: holds one finished transaction until the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    out_len_d   = out_len_q;
    out_val_d   = out_val_q;
    out_drop_d  = out_drop_q;
    if ((state_q == ST_DONE) && out_load) begin
      out_valid_d = 1'b1;
      out_len_d   = LEN_W'(count_q);
      out_val_d   = value_q;
      out_drop_d  = lost_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    add_q      <= add_d;
    target_q   <= target_d;
    bi_q       <= bi_d;
    rising_q   <= rising_d;
    bit_q      <= bit_d;
    ri_q       <= ri_d;
    scan_q     <= scan_d;
    pos_q      <= pos_d;
    lost_q     <= lost_d;
    value_q    <= value_d;
    out_len_q  <= out_len_d;
    out_val_q  <= out_val_d;
    out_drop_q <= out_drop_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.list_length = out_len_q;
  assign out_o.entry_value = out_val_q;
  assign out_o.dropped     = out_drop_q;

endmodule

/* hw/rtl/apl_checker.sv */
module apl_checker #(
  parameter int unsigned LIST_DEPTH = apl_pkg::DEF_LIST_DEPTH
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [apl_pkg::LEN_W-1:0]   list_length_i,
  input logic [apl_pkg::VAL_W-1:0]   entry_value_i,
  input logic                        dropped_i
);
  import apl_pkg::*;

  // The block works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input accepted while a transaction was in progress");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(list_length_i) && $stable(entry_value_i) && $stable(dropped_i)))
    else $error("stalled result changed");

  // A drop is only reported on a full list.
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && dropped_i) |-> (list_length_i == LEN_W'(LIST_DEPTH)))
    else $error("drop reported on a list that is not full");

  // A nonzero entry can only come from a nonempty list.
  a_value_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (entry_value_i != '0)) |-> (list_length_i != '0))
    else $error("entry returned from an empty list");

endmodule

bind active_point_list_core apl_checker #(.LIST_DEPTH(LIST_DEPTH)) u_apl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .list_length_i (out_o.list_length),
  .entry_value_i (out_o.entry_value),
  .dropped_i     (out_o.dropped)
);
